/* rtl/rwfa_pkg.sv */
`default_nettype none
package rwfa_pkg;

  localparam int unsigned MaxEntriesDef = 64;
  localparam logic [23:0] RadiusReset   = 24'd5120;
  localparam logic [23:0] RadiusMin     = 24'd256;

  localparam logic [1:0] ModeAdd   = 2'd0;
  localparam logic [1:0] ModeQuery = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
  } req_t;

  typedef struct packed {
    logic signed [15:0] force_x;
    logic signed [15:0] force_y;
    logic [6:0]         used_count;
    logic               status;
  } rsp_t;

  // Table entry as stored in the entry memory.
  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] frc_x;
    logic signed [15:0] frc_y;
  } entry_t;

endpackage
`default_nettype wire

/* rtl/radius_weighted_field_average.sv */
// Add, clear and no-op requests: the result goes through the SOut state to the output register.
// A query over N stored entries, M of them within the radius, visits each entry in turn
// and, when M > 0, ends with the two 48-step averaging divisions.
// Per entry: read, root start, 25 root steps, then 48 weight-division steps if in range.
// A new request is taken once the previous result has been taken, at the earliest in its cycle.
// Reset (rst_ni low, asynchronous) empties the table and sets the radius to 20 m.
`default_nettype none
module radius_weighted_field_average
  import rwfa_pkg::*;
#(
  parameter int unsigned MaxEntries = MaxEntriesDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire req_t  in_data_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output rsp_t       out_data_o,
  input  wire logic  cfg_we_i,
  input  wire logic [23:0] cfg_data_i
);

  localparam int unsigned AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CW = $clog2(MaxEntries + 1);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SRead  = 4'd1;
  localparam logic [3:0] SSqrtS = 4'd2;
  localparam logic [3:0] SSqrt  = 4'd3;
  localparam logic [3:0] SFrac  = 4'd4;
  localparam logic [3:0] SSq    = 4'd5;
  localparam logic [3:0] SMul   = 4'd6;
  localparam logic [3:0] SAcc   = 4'd7;
  localparam logic [3:0] SDivX  = 4'd8;
  localparam logic [3:0] SDivY  = 4'd9;
  localparam logic [3:0] SOut   = 4'd10;
  localparam logic [3:0] SWaitX = 4'd11;
  localparam logic [3:0] SWaitY = 4'd12;

  logic [3:0]  st_q, st_d;
  logic [23:0] radius_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] used_q, used_d;
  req_t        req_q;
  rsp_t        rsp_q, rsp_d;
  logic        ovalid_q, ovalid_d;
  logic signed [25+CW+16:0] sumx_q, sumx_d, sumy_q, sumy_d;
  logic [24:0] dist_q, dist_d;
  logic [16:0] w_q, w_d;
  logic [16:0] frac_q, frac_d;
  logic signed [33:0] px_q, py_q;

  // Entry memory access.
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  assign we    = (st_q == SIdle) && in_valid_i && in_ready_o &&
                 (in_data_i.mode == ModeAdd) && (count_q < CW'(MaxEntries));
  assign waddr = count_q[AW-1:0];
  assign wdata = '{pos_x: in_data_i.pos_x, pos_y: in_data_i.pos_y,
                   frc_x: in_data_i.vec_x, frc_y: in_data_i.vec_y};
  assign raddr = idx_q[AW-1:0];

  rwfa_ram #(.Width($bits(entry_t)), .Depth(MaxEntries)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Squared distance for the entry just read.
  logic signed [24:0] dx, dy;
  logic [49:0] d2;
  assign dx = 25'(req_q.pos_x) - 25'(rdata.pos_x);
  assign dy = 25'(req_q.pos_y) - 25'(rdata.pos_y);
  assign d2 = 50'(dx * dx) + 50'(dy * dy);

  // The read data is valid in SSqrtS, where the root starts.
  entry_t ent_q;
  logic   sq_start, sq_done;
  logic [24:0] sq_root;
  rwfa_isqrt u_sqrt (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(sq_start), .val_i(d2),
    .done_o(sq_done), .root_o(sq_root)
  );

  // Shared divider: weight fraction and final averages.
  logic        dv_start, dv_done;
  logic [47:0] dv_num, dv_quo;
  logic [23:0] dv_den;
  rwfa_div #(.NumW(48), .DenW(24)) u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(dv_start), .num_i(dv_num),
    .den_i(dv_den), .done_o(dv_done), .quo_o(dv_quo)
  );

  logic [47:0] absx, absy;
  assign absx = sumx_q[25+CW+16] ? 48'(-sumx_q) : 48'(sumx_q);
  assign absy = sumy_q[25+CW+16] ? 48'(-sumy_q) : 48'(sumy_q);

  // Quotient of |sum| by count, then by 65536, with sign restored.
  function automatic logic [15:0] negx_fix(input logic neg, input logic [47:0] q);
    logic [15:0] m;
    m = q[31:16];
    return neg ? 16'(-m) : m;
  endfunction

  // Weight fraction for an entry in range; averages divide |sum| by count, drop 16 fraction bits.
  always_comb begin
    dv_num = '0;
    dv_den = '0;
    dv_start = 1'b0;
    case (st_q)
      SFrac: begin
        dv_num   = {8'd0, 24'(radius_q - 24'(dist_q)), 16'd0};
        dv_den   = radius_q;
        dv_start = 1'b0;
      end
      default: ;
    endcase
    if (st_q == SSqrt && sq_done && (sq_root < {1'b0, radius_q})) begin
      dv_num   = {8'd0, 24'(radius_q - sq_root[23:0]), 16'd0};
      dv_den   = radius_q;
      dv_start = 1'b1;
    end
    if (st_q == SAcc && idx_d == count_q && used_q != '0 && idx_q + CW'(1) == count_q) begin
      dv_start = 1'b0;
    end
    if (st_q == SDivX) begin
      dv_num   = absx;
      dv_den   = 24'(used_q);
      dv_start = 1'b1;
    end
    if (st_q == SDivY) begin
      dv_num   = absy;
      dv_den   = 24'(used_q);
      dv_start = 1'b1;
    end
  end

  // Sequencer over the stored entries.
  always_comb begin
    st_d     = st_q;
    count_d  = count_q;
    idx_d    = idx_q;
    used_d   = used_q;
    rsp_d    = rsp_q;
    ovalid_d = ovalid_q;
    sumx_d   = sumx_q;
    sumy_d   = sumy_q;
    dist_d   = dist_q;
    w_d      = w_q;
    frac_d   = frac_q;
    sq_start = 1'b0;
    if (out_valid_o && out_ready_i) ovalid_d = 1'b0;
    case (st_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          rsp_d = '0;
          idx_d = '0;
          used_d = '0;
          sumx_d = '0;
          sumy_d = '0;
          case (in_data_i.mode)
            ModeAdd: begin
              if (count_q < CW'(MaxEntries)) count_d = count_q + CW'(1);
              else rsp_d.status = 1'b1;
              st_d = SOut;
            end
            ModeQuery: st_d = (count_q == '0) ? SOut : SRead;
            ModeClear: begin
              count_d = '0;
              st_d = SOut;
            end
            default: st_d = SOut;
          endcase
        end
      end
      SRead:  st_d = SSqrtS;
      SSqrtS: begin
        sq_start = 1'b1;
        st_d = SSqrt;
      end
      SSqrt: begin
        if (sq_done) begin
          dist_d = sq_root;
          st_d = (sq_root < {1'b0, radius_q}) ? SFrac : SAcc;
        end
      end
      SFrac: begin
        if (dv_done) begin
          frac_d = dv_quo[16:0];
          st_d = SSq;
        end
      end
      SSq: st_d = SMul;
      SMul: begin
        w_d = w_q;
        st_d = SAcc;
      end
      SAcc: begin
        if (dist_q < {1'b0, radius_q}) begin
          used_d = used_q + CW'(1);
          sumx_d = sumx_q + (25+CW+17)'(px_q);
          sumy_d = sumy_q + (25+CW+17)'(py_q);
        end
        idx_d = idx_q + CW'(1);
        if (idx_q + CW'(1) == count_q) begin
          st_d = (used_d == '0) ? SOut : SDivX;
        end else begin
          st_d = SRead;
        end
      end
      SDivX: st_d = SWaitX;
      SWaitX: begin
        if (dv_done) begin
          rsp_d.force_x = negx_fix(sumx_q[25+CW+16], dv_quo);
          st_d = SDivY;
        end
      end
      SDivY: st_d = SWaitY;
      SWaitY: begin
        if (dv_done) begin
          rsp_d.force_y = negx_fix(sumy_q[25+CW+16], dv_quo);
          rsp_d.used_count = 7'(used_q);
          st_d = SOut;
        end
      end
      SOut: begin
        if (!ovalid_q || (out_valid_o && out_ready_i)) begin
          ovalid_d = 1'b1;
          st_d = SIdle;
        end
      end
      default: st_d = SIdle;
    endcase
  end

  // A new request waits until the pending result is taken.
  assign in_ready_o  = (st_q == SIdle) && (!ovalid_q || out_ready_i);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= SIdle;
      radius_q <= RadiusReset;
      count_q  <= '0;
      idx_q    <= '0;
      used_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      used_q   <= used_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) radius_q <= (cfg_data_i < RadiusMin) ? RadiusMin : cfg_data_i;
    end
  end

  // Datapath registers: square, weight products.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_data_i;
    if (st_q == SRead) ent_q <= ent_q;
    if (st_q == SSqrtS) ent_q <= rdata;
    rsp_q  <= rsp_d;
    sumx_q <= sumx_d;
    sumy_q <= sumy_d;
    dist_q <= dist_d;
    frac_q <= frac_d;
    if (st_q == SSq) w_q <= 17'((34'(frac_q) * 34'(frac_q)) >> 16);
    else w_q <= w_d;
    if (st_q == SMul) begin
      px_q <= 34'($signed({1'b0, w_q})) * 34'(ent_q.frc_x);
      py_q <= 34'($signed({1'b0, w_q})) * 34'(ent_q.frc_y);
    end
  end

endmodule
`default_nettype wire

/* rtl/rwfa_ram.sv */
`default_nettype none
module rwfa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0]      rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Single write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/rwfa_isqrt.sv */
`default_nettype none
module rwfa_isqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [49:0] val_i,
  output logic             done_o,
  output logic [24:0]      root_o
);

  // Restoring square root, one result bit per cycle.
  logic [49:0] rem_q, rem_d;
  logic [24:0] root_q, root_d;
  logic [49:0] val_q, val_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [26:0] trial;
  logic [26:0] remsh;

  assign remsh = {rem_q[24:0], val_q[49:48]};
  assign trial = {root_q, 2'b01};

  always_comb begin
    rem_d  = rem_q;
    root_d = root_q;
    val_d  = val_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      root_d = '0;
      val_d  = val_i;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[47:0], 2'b00};
      if (remsh >= trial) begin
        rem_d  = {23'd0, remsh - trial};
        root_d = {root_q[23:0], 1'b1};
      end else begin
        rem_d  = {23'd0, remsh};
        root_d = {root_q[23:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd24) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign root_o = root_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    val_q  <= val_d;
  end

endmodule
`default_nettype wire

/* rtl/rwfa_div.sv */
`default_nettype none
module rwfa_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 24
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  // Unsigned restoring divider, one quotient bit per cycle.
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   sh;

  assign sh = {rem_q[DenW-1:0], quo_q[NumW-1]};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(NumW - 1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quo_o = quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

endmodule
`default_nettype wire

/* rtl/rwfa_checker.sv */
`default_nettype none
module rwfa_checker
  import rwfa_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire req_t in_data_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire rsp_t out_data_o
);

  // A pending result holds steady until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Status and a nonzero used count never both show.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.used_count == 7'd0)
    else $error("drop flag with used count");

  // No used entries means zero force.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.used_count == 7'd0 |->
      out_data_o.force_x == 16'sd0 && out_data_o.force_y == 16'sd0)
    else $error("force with no entries");

  // A request is not taken in the cycle after one.
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("back to back request");

endmodule

bind radius_weighted_field_average rwfa_checker u_chk (.*);
`default_nettype wire

/* bench/radius_weighted_field_average_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module radius_weighted_field_average_tb;
  import rwfa_pkg::*;

  localparam int unsigned TableDepth = MaxEntriesDef;
  localparam logic [1:0] ModeNop = 2'd3;
  localparam longint CycleLimit = 20000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [23:0] cfg_data_i = '0;

  radius_weighted_field_average u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state: the table of current vectors and the influence radius.
  logic signed [23:0] tbl_pos_x [TableDepth];
  logic signed [23:0] tbl_pos_y [TableDepth];
  logic signed [15:0] tbl_frc_x [TableDepth];
  logic signed [15:0] tbl_frc_y [TableDepth];
  int unsigned        tbl_count;
  logic [23:0]        cur_radius;

  req_t pending_requests [$];
  rsp_t expected_forces [$];
  int   err_count;
  bit   quiet;          // no idling on either side while set
  longint cycles;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Append one request to the pending queue.
  task automatic queue_req(input req_t rq);
    pending_requests = {pending_requests, rq};
  endtask

  // Bitwise integer square root of a 64-bit value.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned rem, root, bitv;
    rem = v;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Compute the expected response for one request and update the table.
  function automatic rsp_t predict_field(input req_t rq);
    rsp_t r;
    longint sum_x, sum_y, dx, dy, w, dv;
    longint unsigned d2, reach, frac, rad;
    int unsigned cnt;
    r = '0;
    rad = cur_radius;
    case (rq.mode)
      ModeAdd: begin
        if (tbl_count >= TableDepth) begin
          r.status = 1'b1;
        end else begin
          tbl_pos_x[tbl_count] = rq.pos_x;
          tbl_pos_y[tbl_count] = rq.pos_y;
          tbl_frc_x[tbl_count] = rq.vec_x;
          tbl_frc_y[tbl_count] = rq.vec_y;
          tbl_count++;
        end
      end
      ModeQuery: begin
        sum_x = 0;
        sum_y = 0;
        cnt = 0;
        for (int i = 0; i < tbl_count; i++) begin
          dx = longint'(rq.pos_x) - longint'(tbl_pos_x[i]);
          dy = longint'(rq.pos_y) - longint'(tbl_pos_y[i]);
          d2 = longint'(dx * dx) + longint'(dy * dy);
          reach = int_sqrt(d2);
          if (reach < rad) begin
            frac = ((rad - reach) << 16) / rad;
            w = longint'((frac * frac) >> 16);
            cnt++;
            sum_x += w * longint'(tbl_frc_x[i]);
            sum_y += w * longint'(tbl_frc_y[i]);
          end
        end
        if (cnt != 0) begin
          dv = longint'(cnt) * 65536;
          r.force_x = 16'(sum_x / dv);
          r.force_y = 16'(sum_y / dv);
          r.used_count = 7'(cnt);
        end
      end
      ModeClear: tbl_count = 0;
      default: ;
    endcase
    return r;
  endfunction

  // Driver: present the oldest pending request, predicting it on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_forces = {expected_forces, predict_field(in_data_i)};
        void'(pending_requests.pop_front());
      end
      if ((!in_valid_i || in_ready_o) && pending_requests.size() > 0 &&
          (quiet || $urandom_range(99) >= 29)) begin
        if (in_valid_i && in_ready_o && pending_requests.size() == 0) begin
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_requests[0];
        end
      end else if (in_valid_i && in_ready_o) begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: stall the output at random and check each response.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_forces.size() == 0) begin
          $display("%0t: unexpected response %h", $time, out_data_o);
          err_count++;
        end else begin
          rsp_t ex;
          ex = expected_forces.pop_front();
          if (ex.force_x !== out_data_o.force_x)
            $display("%0t: force_x expected %0d actual %0d", $time, ex.force_x,
                     out_data_o.force_x);
          if (ex.force_y !== out_data_o.force_y)
            $display("%0t: force_y expected %0d actual %0d", $time, ex.force_y,
                     out_data_o.force_y);
          if (ex.used_count !== out_data_o.used_count)
            $display("%0t: used_count expected %0d actual %0d", $time, ex.used_count,
                     out_data_o.used_count);
          if (ex.status !== out_data_o.status)
            $display("%0t: status expected %0d actual %0d", $time, ex.status,
                     out_data_o.status);
          if (ex !== out_data_o) err_count++;
        end
      end
      out_ready_i <= quiet || ($urandom_range(99) >= 29);
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic req_t make_req(input logic [1:0] m, input logic [23:0] x,
                                    input logic [23:0] y, input logic [15:0] vx,
                                    input logic [15:0] vy);
    req_t rq;
    rq.mode = m;
    rq.pos_x = x;
    rq.pos_y = y;
    rq.vec_x = vx;
    rq.vec_y = vy;
    return rq;
  endfunction

  // Wait for the block to drain, then write the radius.
  task automatic set_radius(input logic [23:0] val);
    wait (pending_requests.size() == 0 && expected_forces.size() == 0 && !in_valid_i);
    repeat (10) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_radius = (val < RadiusMin) ? RadiusMin : val;
  endtask

  // One random request; mostly entries clustered near the origin, so queries hit.
  function automatic req_t rand_req(input int spread);
    logic [1:0] m;
    int sel;
    sel = $urandom_range(99);
    m = (sel < 55) ? ModeAdd : (sel < 92) ? ModeQuery : (sel < 97) ? ModeClear : ModeNop;
    if ($urandom_range(9) == 0)
      return make_req(m, 24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom));
    return make_req(m, 24'($signed($urandom_range(2 * spread)) - spread),
                    24'($signed($urandom_range(2 * spread)) - spread),
                    16'($urandom), 16'($urandom));
  endfunction

  initial begin
    logic [23:0] radii [5];
    err_count = 0;
    cycles = 0;
    quiet = 1'b0;
    tbl_count = 0;
    cur_radius = RadiusReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty query, field extremes, exact distance edges, every mode.
    queue_req(make_req(ModeQuery, 0, 0, 0, 0));
    queue_req(make_req(ModeAdd, 0, 0, 16'h7fff, 16'h8000));
    queue_req(make_req(ModeAdd, 24'd5120, 0, 16'h8000, 16'h7fff));
    queue_req(make_req(ModeAdd, 24'h7fffff, 24'h800000, 16'hffff, 1));
    queue_req(make_req(ModeAdd, 24'h800000, 24'h7fffff, 1, 16'hffff));
    queue_req(make_req(ModeQuery, 0, 0, 16'h1234, 16'h5678));
    queue_req(make_req(ModeQuery, 24'd5119, 0, 0, 0));
    queue_req(make_req(ModeQuery, 24'h7fffff, 24'h800000, 0, 0));
    queue_req(make_req(ModeQuery, 24'h800000, 24'h7fffff, 0, 0));
    queue_req(make_req(ModeNop, 24'hffffff, 24'hffffff, 16'hffff, 16'hffff));
    queue_req(make_req(ModeClear, 0, 0, 0, 0));
    queue_req(make_req(ModeQuery, 0, 0, 0, 0));
    // Fill the table past capacity to exercise the dropped add.
    for (int i = 0; i < TableDepth + 2; i++)
      queue_req(make_req(ModeAdd, 24'(i * 40), 24'(-i * 30),
                         16'(i * 500), 16'(-i * 700)));
    queue_req(make_req(ModeQuery, 24'd600, 24'hfffe00, 0, 0));
    queue_req(make_req(ModeClear, 0, 0, 0, 0));

    // Random phases over several radius settings, extremes included.
    radii[0] = 24'd0;
    radii[1] = 24'hffffff;
    radii[2] = 24'd300;
    radii[3] = 24'd2000;
    radii[4] = 24'd5120;
    for (int p = 0; p < 5; p++) begin
      set_radius(radii[p]);
      quiet = (p == 3);
      for (int i = 0; i < 125; i++)
        queue_req(rand_req(p == 1 ? 8000000 : 3000));
      queue_req(make_req(ModeClear, 0, 0, 0, 0));
    end

    wait (pending_requests.size() == 0 && expected_forces.size() == 0);
    repeat (400) @(posedge clk_i);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* radius_weighted_field_average.f */
rtl/rwfa_pkg.sv
rtl/rwfa_ram.sv
rtl/rwfa_isqrt.sv
rtl/rwfa_div.sv
rtl/radius_weighted_field_average.sv
rtl/rwfa_checker.sv
bench/radius_weighted_field_average_tb.sv
